/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms sampled on clk, one of them disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property checked on every rising clk edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// property checked on every rising clk edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* src/hspd_pkg.sv */
// ----------------------------------------------------------------------------
// hspd_pkg
// types and constants for the hall sensor position decoder
// ----------------------------------------------------------------------------
package hspd_pkg;

	localparam int FAULT_WIDTH = 31;
	localparam logic [FAULT_WIDTH-1:0] FAULT_MAX = {FAULT_WIDTH{1'b1}};

	typedef logic [2:0] hall_t;

	typedef enum logic [1:0] {
		REQ_EDGE   = 2'd0,
		REQ_PRESET = 2'd1,
		REQ_INIT   = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		SEL_V = 2'd0,
		SEL_W = 2'd1,
		SEL_U = 2'd2
	} sel_t;

	typedef enum logic [1:0] {
		OUT_NONE  = 2'd0,
		OUT_CW    = 2'd1,
		OUT_CCW   = 2'd2,
		OUT_FAULT = 2'd3
	} outcome_t;

	// result of evaluating one phase edge against the stored code
	typedef struct packed {
		outcome_t outcome;
		hall_t    next_code;
	} step_t;

	// clockwise order 1->3->2->6->4->5->1
	function automatic hall_t cw_succ(input hall_t cur);
		hall_t r;
		case (cur)
			3'd1: r = 3'd3;
			3'd2: r = 3'd6;
			3'd3: r = 3'd2;
			3'd4: r = 3'd5;
			3'd5: r = 3'd1;
			3'd6: r = 3'd4;
			default: r = 3'd0;
		endcase
		return r;
	endfunction

	function automatic hall_t ccw_succ(input hall_t cur);
		hall_t r;
		case (cur)
			3'd1: r = 3'd5;
			3'd2: r = 3'd3;
			3'd3: r = 3'd1;
			3'd4: r = 3'd6;
			3'd5: r = 3'd4;
			3'd6: r = 3'd2;
			default: r = 3'd0;
		endcase
		return r;
	endfunction

endpackage

/* src/hspd_step.sv */
// ----------------------------------------------------------------------------
// hspd_step
// classifies one phase edge as clockwise, counter-clockwise, fault or ignored
// ----------------------------------------------------------------------------
module hspd_step import hspd_pkg::*; (
	input  hall_t      cur_code,
	input  logic [1:0] phase_sel,
	input  logic       level,
	output step_t      step
);

	hall_t cand;
	logic  sel_ok;

	always_comb begin
		cand   = cur_code;
		sel_ok = 1'b1;
		case (sel_t'(phase_sel))
			SEL_V: begin
				cand = {level, cur_code[1:0]};
			end
			SEL_W: begin
				cand = {cur_code[2], level, cur_code[0]};
			end
			SEL_U: begin
				cand = {cur_code[2:1], level};
			end
			default: begin
				sel_ok = 1'b0;
			end
		endcase
	end

	always_comb begin
		step.next_code = cur_code;
		step.outcome   = OUT_NONE;
		// no decoding until a nonzero code has been captured
		if (cur_code != 3'd0 && sel_ok) begin
			if (cand == cw_succ(cur_code)) begin
				step.next_code = cand;
				step.outcome   = OUT_CW;
			end else if (cand == ccw_succ(cur_code)) begin
				step.next_code = cand;
				step.outcome   = OUT_CCW;
			end else begin
				step.outcome = OUT_FAULT;
			end
		end
	end

endmodule

/* src/hall_sensor_position_decoder_top.sv */
// ----------------------------------------------------------------------------
// hall_sensor_position_decoder_top
// turns hall line events into a signed position count with fault tracking
// ----------------------------------------------------------------------------
// usage:
//  input channel (in_valid / in_stall) carries one request: phase edge,
//  count preset or initialize from the three line levels
//  output channel (out_valid / out_stall) returns exactly one result per
//  request: count after and before, fault total, direction, code, outcome
//  a request sits in the input register until the result register is free; decode
//  and state update then load the result register
//  throughput is one request per cycle while out_stall does not hold the result;
//  the decode plus the count increment/decrement sit between the two registers
//  reset clears the hall code (decoder uninitialized), the count, the fault
//  total and the direction, and empties both registers
//  when out_stall holds the result, the input register keeps its request and
//  in_stall rises until the result is taken
//  edges before an initialize with a nonzero code are reported as no step
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hall_sensor_position_decoder_top import hspd_pkg::*; #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,

	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [1:0]             req_type,
	input  logic [1:0]             phase_sel,
	input  logic                   level,
	input  logic                   hall_v,
	input  logic                   hall_w,
	input  logic                   hall_u,
	input  logic signed [31:0]     count_value,

	output logic                   out_valid,
	input  logic                   out_stall,
	output logic signed [31:0]     position_count,
	output logic signed [31:0]     previous_count,
	output logic [FAULT_WIDTH-1:0] fault_total,
	output logic                   rotation_dir,
	output logic [2:0]             hall_code,
	output logic [1:0]             step_outcome
);

	localparam int EXT_W = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

	// input register
	logic                   valid_s1;
	logic [1:0]             req_s1;
	logic [1:0]             sel_s1;
	logic                   level_s1;
	hall_t                  init_code_s1;
	logic signed [31:0]     preset_s1;

	// decoder state
	hall_t                  hall_q;
	logic [COUNT_WIDTH-1:0] tick_q;
	logic [FAULT_WIDTH-1:0] fault_q;
	logic                   dir_q;

	// result register
	logic                   out_valid_q;
	logic [31:0]            pos_q;
	logic [31:0]            prev_q;
	logic [FAULT_WIDTH-1:0] fault_out_q;
	logic                   dir_out_q;
	hall_t                  hall_out_q;
	outcome_t               outcome_q;

	logic                   out_free;
	logic                   adv_s1;
	logic                   take_in;
	step_t                  step;

	hall_t                  hall_d;
	logic [COUNT_WIDTH-1:0] tick_d;
	logic [FAULT_WIDTH-1:0] fault_d;
	logic                   dir_d;
	outcome_t               outcome_d;
	logic signed [EXT_W-1:0] preset_ext;
	logic [EXT_W-1:0]       tick_d_ext;
	logic [EXT_W-1:0]       tick_q_ext;

	assign out_free = !out_valid_q || !out_stall;
	assign adv_s1   = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign take_in  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			req_s1       <= req_type;
			sel_s1       <= phase_sel;
			level_s1     <= level;
			init_code_s1 <= {hall_v, hall_w, hall_u};
			preset_s1    <= count_value;
		end
	end

	hspd_step u_step (
		.cur_code  (hall_q),
		.phase_sel (sel_s1),
		.level     (level_s1),
		.step      (step)
	);

	assign preset_ext = EXT_W'(preset_s1);

	always_comb begin
		hall_d    = hall_q;
		tick_d    = tick_q;
		fault_d   = fault_q;
		dir_d     = dir_q;
		outcome_d = OUT_NONE;
		case (req_t'(req_s1))
			REQ_EDGE: begin
				outcome_d = step.outcome;
				hall_d    = step.next_code;
				case (step.outcome)
					OUT_CW: begin
						tick_d = tick_q + COUNT_WIDTH'(1);
						dir_d  = 1'b0;
					end
					OUT_CCW: begin
						tick_d = tick_q - COUNT_WIDTH'(1);
						dir_d  = 1'b1;
					end
					OUT_FAULT: begin
						if (fault_q != FAULT_MAX) begin
							fault_d = fault_q + FAULT_WIDTH'(1);
						end
					end
					default: begin
						tick_d = tick_q;
					end
				endcase
			end
			REQ_PRESET: begin
				tick_d = preset_ext[COUNT_WIDTH-1:0];
			end
			REQ_INIT: begin
				// a second init is ignored once a code is held
				if (hall_q == 3'd0) begin
					hall_d  = init_code_s1;
					tick_d  = '0;
					fault_d = '0;
					dir_d   = 1'b0;
				end
			end
			default: begin
				hall_d = hall_q;
			end
		endcase
	end

	assign tick_d_ext = EXT_W'(tick_d);
	assign tick_q_ext = EXT_W'(tick_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hall_q      <= '0;
			tick_q      <= '0;
			fault_q     <= '0;
			dir_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv_s1) begin
				hall_q      <= hall_d;
				tick_q      <= tick_d;
				fault_q     <= fault_d;
				dir_q       <= dir_d;
				out_valid_q <= 1'b1;
			end else if (out_free) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			pos_q       <= tick_d_ext[31:0];
			prev_q      <= tick_q_ext[31:0];
			fault_out_q <= fault_d;
			dir_out_q   <= dir_d;
			hall_out_q  <= hall_d;
			outcome_q   <= outcome_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign position_count = pos_q;
	assign previous_count = prev_q;
	assign fault_total    = fault_out_q;
	assign rotation_dir   = dir_out_q;
	assign hall_code      = hall_out_q;
	assign step_outcome   = outcome_q;

	`ASSERT_CLK(a_stall_only_when_blocked, !in_stall || (out_valid && out_stall), "input stalled while result side free")
	`ASSERT_CLK(a_state_holds_when_idle, !adv_s1 |=> ($stable(tick_q) && $stable(hall_q) && $stable(fault_q)), "decoder state changed without a request")
	`ASSERT_CLK(a_step_moves_count, (out_valid && (step_outcome == OUT_CW || step_outcome == OUT_CCW)) |-> (position_count != previous_count && hall_code != 3'd0), "step reported without count change")
	`ASSERT_CLK(a_fault_keeps_code, (adv_s1 && outcome_d == OUT_FAULT) |=> $stable(hall_q), "fault changed the hall code")

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// hall sensor position decoder: a scripted opening (pre-init edges, init
// corner cases, full cw and ccw laps, count wrap in both directions, bad
// selects and requests) followed by random rotation runs with faults, presets
// and noise, scored field by field against a cycle-free decoder model or
// fixed expected values, with random gaps and stalls on both channels
// ----------------------------------------------------------------------------
module tb import hspd_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 1030;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_LEN = 150;
	localparam int HOLD_AT_A = 400;
	localparam int HOLD_AT_B = 3000;

	// codes outside the enums, used to hit the ignore paths
	localparam logic [1:0] REQ_BAD = 2'd3;
	localparam logic [1:0] SEL_BAD = 2'd3;

	localparam hall_t CW_NEXT [0:7] = '{3'd0, 3'd3, 3'd6, 3'd2, 3'd5, 3'd1, 3'd4, 3'd0};
	localparam hall_t CCW_NEXT [0:7] = '{3'd0, 3'd5, 3'd3, 3'd1, 3'd6, 3'd4, 3'd2, 3'd0};
	localparam logic [31:0] COUNT_CORNERS [0:5] = '{32'h7FFF_FFFF, 32'h8000_0000,
		32'hFFFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFE, 32'h8000_0001};

	typedef struct packed {
		logic [1:0]  req;
		logic [1:0]  sel;
		logic        level;
		logic [2:0]  lines;
		logic [31:0] count;
	} hall_item_t;

	typedef struct packed {
		logic [31:0]            pos;
		logic [31:0]            prev;
		logic [FAULT_WIDTH-1:0] fault;
		logic                   dir;
		hall_t                  code;
		outcome_t               outcome;
	} decoded_t;

	typedef struct packed {
		hall_item_t it;
		logic       typed;
		decoded_t   want;
	} script_row_t;

	localparam decoded_t NO_WANT = '0;
	localparam int SCRIPT_LEN = 25;
	localparam script_row_t SCRIPT [0:SCRIPT_LEN-1] = '{
		// edge before init, preset and all-low init while uninitialized
		'{'{REQ_EDGE, SEL_V, 1'b1, 3'b101, 32'h0000_0000}, 1'b1,
			'{32'h0, 32'h0, 31'h0, 1'b0, 3'd0, OUT_NONE}},
		'{'{REQ_PRESET, SEL_U, 1'b0, 3'b000, 32'h7FFF_FFFF}, 1'b1,
			'{32'h7FFF_FFFF, 32'h0, 31'h0, 1'b0, 3'd0, OUT_NONE}},
		'{'{REQ_INIT, SEL_W, 1'b1, 3'b000, 32'hFFFF_FFFF}, 1'b1,
			'{32'h0, 32'h7FFF_FFFF, 31'h0, 1'b0, 3'd0, OUT_NONE}},
		'{'{REQ_EDGE, SEL_U, 1'b1, 3'b111, 32'h8000_0000}, 1'b1,
			'{32'h0, 32'h0, 31'h0, 1'b0, 3'd0, OUT_NONE}},
		'{'{REQ_INIT, SEL_V, 1'b0, 3'b001, 32'h5555_5555}, 1'b0, NO_WANT},
		// repeated init, ignored
		'{'{REQ_INIT, SEL_V, 1'b0, 3'b110, 32'hAAAA_AAAA}, 1'b0, NO_WANT},
		'{'{REQ_EDGE, SEL_W, 1'b1, 3'b000, 32'h0}, 1'b0, NO_WANT},
		'{'{REQ_PRESET, SEL_V, 1'b1, 3'b111, 32'h7FFF_FFFF}, 1'b0, NO_WANT},
		// cw step across the positive wrap
		'{'{REQ_EDGE, SEL_W, 1'b1, 3'b000, 32'h0}, 1'b0, NO_WANT},
		'{'{REQ_EDGE, SEL_U, 1'b0, 3'b010, 32'h1234_5678}, 1'b0, NO_WANT},
		'{'{REQ_EDGE, SEL_V, 1'b1, 3'b000, 32'h0}, 1'b0, NO_WANT},
		'{'{REQ_EDGE, SEL_W, 1'b0, 3'b000, 32'h0}, 1'b0, NO_WANT},
		'{'{REQ_EDGE, SEL_U, 1'b1, 3'b000, 32'h0}, 1'b0, NO_WANT},
		'{'{REQ_EDGE, SEL_V, 1'b0, 3'b000, 32'h0}, 1'b0, NO_WANT},
		'{'{REQ_EDGE, SEL_BAD, 1'b1, 3'b011, 32'h0}, 1'b0, NO_WANT},
		'{'{REQ_BAD, SEL_BAD, 1'b1, 3'b111, 32'hFFFF_FFFF}, 1'b0, NO_WANT},
		'{'{REQ_PRESET, SEL_W, 1'b0, 3'b100, 32'h8000_0000}, 1'b0, NO_WANT},
		// ccw lap, first step crosses the negative wrap
		'{'{REQ_EDGE, SEL_V, 1'b1, 3'b000, 32'h0}, 1'b0, NO_WANT},
		'{'{REQ_EDGE, SEL_U, 1'b0, 3'b000, 32'h0}, 1'b0, NO_WANT},
		'{'{REQ_EDGE, SEL_W, 1'b1, 3'b000, 32'h0}, 1'b0, NO_WANT},
		'{'{REQ_EDGE, SEL_V, 1'b0, 3'b000, 32'h0}, 1'b0, NO_WANT},
		'{'{REQ_EDGE, SEL_U, 1'b1, 3'b000, 32'h0}, 1'b0, NO_WANT},
		'{'{REQ_EDGE, SEL_W, 1'b0, 3'b000, 32'h0}, 1'b0, NO_WANT},
		// jump to code zero is no neighbor
		'{'{REQ_EDGE, SEL_U, 1'b0, 3'b000, 32'h0}, 1'b0, NO_WANT},
		'{'{REQ_PRESET, SEL_U, 1'b1, 3'b000, 32'hFFFF_FFFF}, 1'b0, NO_WANT}
	};

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic [1:0]             req_type = '0;
	logic [1:0]             phase_sel = '0;
	logic                   level = 1'b0;
	logic                   hall_v = 1'b0;
	logic                   hall_w = 1'b0;
	logic                   hall_u = 1'b0;
	logic signed [31:0]     count_value = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic signed [31:0]     position_count;
	logic signed [31:0]     previous_count;
	logic [FAULT_WIDTH-1:0] fault_total;
	logic                   rotation_dir;
	logic [2:0]             hall_code;
	logic [1:0]             step_outcome;

	// decoder model state
	hall_t                  code_now = '0;
	logic [31:0]            tick_now = '0;
	logic [FAULT_WIDTH-1:0] fault_now = '0;
	logic                   dir_now = 1'b0;

	decoded_t decoded_q[$];
	int mismatches = 0;
	logic spin_ccw = 1'b0;
	logic send_quiet = 1'b0;
	logic seven_run = 1'b0;

	hall_sensor_position_decoder_top i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.req_type       (req_type),
		.phase_sel      (phase_sel),
		.level          (level),
		.hall_v         (hall_v),
		.hall_w         (hall_w),
		.hall_u         (hall_u),
		.count_value    (count_value),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.position_count (position_count),
		.previous_count (previous_count),
		.fault_total    (fault_total),
		.rotation_dir   (rotation_dir),
		.hall_code      (hall_code),
		.step_outcome   (step_outcome)
	);

	always #5 clk = ~clk;

	function automatic decoded_t advance_decoder(input hall_item_t it);
		decoded_t r;
		hall_t nxt;
		r.prev = tick_now;
		r.outcome = OUT_NONE;
		case (it.req)
			REQ_EDGE: begin
				if (code_now != 3'd0 && it.sel != SEL_BAD) begin
					nxt = code_now;
					nxt[2 - it.sel] = it.level;
					if (nxt == CW_NEXT[code_now]) begin
						tick_now = tick_now + 32'd1;
						dir_now = 1'b0;
						code_now = nxt;
						r.outcome = OUT_CW;
					end else if (nxt == CCW_NEXT[code_now]) begin
						tick_now = tick_now - 32'd1;
						dir_now = 1'b1;
						code_now = nxt;
						r.outcome = OUT_CCW;
					end else begin
						if (fault_now != FAULT_MAX)
							fault_now = fault_now + 1'b1;
						r.outcome = OUT_FAULT;
					end
				end
			end
			REQ_PRESET: tick_now = it.count;
			REQ_INIT: begin
				if (code_now == 3'd0) begin
					tick_now = '0;
					fault_now = '0;
					dir_now = 1'b0;
					code_now = it.lines;
				end
			end
			default: ;
		endcase
		r.pos = tick_now;
		r.fault = fault_now;
		r.dir = dir_now;
		r.code = code_now;
		return r;
	endfunction

	// mostly legal rotation with direction runs, the rest faults, noise, presets, inits and bad requests
	function automatic hall_item_t random_item();
		hall_item_t it;
		int pick;
		hall_t target;
		hall_t flip;
		it.req = REQ_EDGE;
		it.sel = 2'($urandom_range(0, 2));
		it.level = 1'($urandom_range(0, 1));
		it.lines = 3'($urandom_range(0, 7));
		it.count = $urandom;
		pick = $urandom_range(0, 99);
		if (pick < 72 && code_now != 3'd0 && code_now != 3'd7) begin
			if ($urandom_range(0, 9) < 2)
				spin_ccw = !spin_ccw;
			target = spin_ccw ? CCW_NEXT[code_now] : CW_NEXT[code_now];
			flip = target ^ code_now;
			it.sel = flip[2] ? SEL_V : (flip[1] ? SEL_W : SEL_U);
			it.level = |(target & flip);
		end else if (pick < 80) begin
			it.level = code_now[2 - it.sel];
		end else if (pick < 84) begin
			it.sel = 2'($urandom_range(0, 3));
		end else if (pick < 92) begin
			it.req = REQ_PRESET;
			if ($urandom_range(0, 3) == 0)
				it.count = COUNT_CORNERS[$urandom_range(0, 5)];
		end else if (pick < 96) begin
			it.req = REQ_INIT;
		end else begin
			it.req = REQ_BAD;
		end
		return it;
	endfunction

	function automatic int pick_gap(input int r);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_request(input hall_item_t it, input logic typed, input decoded_t want);
		int gap;
		decoded_t got;
		if ($urandom_range(0, 39) == 0)
			send_quiet = !send_quiet;
		gap = send_quiet ? 0 : pick_gap($urandom_range(0, 99));
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= it.req;
		phase_sel <= it.sel;
		level <= it.level;
		hall_v <= it.lines[2];
		hall_w <= it.lines[1];
		hall_u <= it.lines[0];
		count_value <= it.count;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		got = advance_decoder(it);
		decoded_q.push_back(typed ? want : got);
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		mismatches++;
		$display("%0t mismatch %s: got %h, expected %h", $realtime, what, got, want);
	endtask

	always @(posedge clk) begin : result_check
		decoded_t want;
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			if (decoded_q.size() == 0) begin
				report_mismatch("result with nothing pending", position_count, 32'h0);
			end else begin
				want = decoded_q.pop_front();
				if (position_count !== want.pos)
					report_mismatch("position_count", position_count, want.pos);
				if (previous_count !== want.prev)
					report_mismatch("previous_count", previous_count, want.prev);
				if (fault_total !== want.fault)
					report_mismatch("fault_total", 32'(fault_total), 32'(want.fault));
				if (rotation_dir !== want.dir)
					report_mismatch("rotation_dir", 32'(rotation_dir), 32'(want.dir));
				if (hall_code !== want.code)
					report_mismatch("hall_code", 32'(hall_code), 32'(want.code));
				if (step_outcome !== want.outcome)
					report_mismatch("step_outcome", 32'(step_outcome), 32'(want.outcome));
			end
		end
	end

	// receiver: random stalls plus two long hold-offs to back up the pipe
	initial begin : result_side
		int hold;
		int cyc;
		logic quiet;
		hold = 0;
		cyc = 0;
		quiet = 1'b0;
		forever begin
			@(posedge clk);
			cyc++;
			if ($urandom_range(0, 199) == 0)
				quiet = !quiet;
			if (cyc == HOLD_AT_A || cyc == HOLD_AT_B)
				hold = HOLD_LEN;
			else if (hold == 0 && !quiet)
				hold = pick_gap($urandom_range(0, 99));
			if (hold > 0) begin
				out_stall <= 1'b1;
				hold--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
				idle = 0;
			else
				idle++;
			if (idle >= WATCHDOG_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin : request_side
		hall_item_t it;
		// now and then the first real init captures code seven, after which every
		// edge with a valid select is a fault for the rest of the run
		seven_run = ($urandom_range(0, 15) == 0);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < SCRIPT_LEN; i++) begin
			it = SCRIPT[i].it;
			if (seven_run && it.req == REQ_INIT && it.lines == 3'b001)
				it.lines = 3'b111;
			send_request(it, SCRIPT[i].typed, SCRIPT[i].want);
		end
		for (int i = 0; i < RANDOM_ITEMS; i++)
			send_request(random_item(), 1'b0, NO_WANT);
		in_valid <= 1'b0;
		while (decoded_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
